// ----- rtl/hmf_pkg.sv -----
package hmf_pkg;

  localparam logic [3:0] PH_START      = 4'd0;
  localparam logic [3:0] PH_HEADERS    = 4'd1;
  localparam logic [3:0] PH_BODY       = 4'd2;
  localparam logic [3:0] PH_CHUNK_DATA = 4'd3;
  localparam logic [3:0] PH_CHUNK_TERM = 4'd4;
  localparam logic [3:0] PH_CHUNK_SIZE = 4'd5;
  localparam logic [3:0] PH_TRAILER    = 4'd6;
  localparam logic [3:0] PH_DONE       = 4'd7;
  localparam logic [3:0] PH_ERROR      = 4'd8;

  localparam logic [2:0] VP_LEAD    = 3'd0;
  localparam logic [2:0] VP_DIGITS  = 3'd1;
  localparam logic [2:0] VP_STOPPED = 3'd2;
  localparam logic [2:0] VP_OVER    = 3'd3;
  localparam logic [2:0] VP_NONE    = 3'd4;

  localparam logic [2:0] CLS_START   = 3'd0;
  localparam logic [2:0] CLS_HEADER  = 3'd1;
  localparam logic [2:0] CLS_BODY    = 3'd2;
  localparam logic [2:0] CLS_SIZE    = 3'd3;
  localparam logic [2:0] CLS_TERM    = 3'd4;
  localparam logic [2:0] CLS_TRAILER = 3'd5;
  localparam logic [2:0] CLS_NONE    = 3'd6;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TERM    = 2'd1;
  localparam logic [1:0] ERR_MISSING = 2'd2;
  localparam logic [1:0] ERR_OVER    = 2'd3;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] byte_class;
    logic       line_end;
    logic       message_done;
    logic [1:0] error_code;
  } hmf_result_t;

  function automatic logic [7:0] cl_char(input logic [4:0] i);
    case (i)
      5'd0: cl_char = "C";   5'd1: cl_char = "o";   5'd2: cl_char = "n";
      5'd3: cl_char = "t";   5'd4: cl_char = "e";   5'd5: cl_char = "n";
      5'd6: cl_char = "t";   5'd7: cl_char = "-";   5'd8: cl_char = "L";
      5'd9: cl_char = "e";   5'd10: cl_char = "n";  5'd11: cl_char = "g";
      5'd12: cl_char = "t";  5'd13: cl_char = "h";
      default: cl_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] i);
    case (i)
      5'd0: te_char = "T";   5'd1: te_char = "r";   5'd2: te_char = "a";
      5'd3: te_char = "n";   5'd4: te_char = "s";   5'd5: te_char = "f";
      5'd6: te_char = "e";   5'd7: te_char = "r";   5'd8: te_char = "-";
      5'd9: te_char = "E";   5'd10: te_char = "n";  5'd11: te_char = "c";
      5'd12: te_char = "o";  5'd13: te_char = "d";  5'd14: te_char = "i";
      5'd15: te_char = "n";  5'd16: te_char = "g";
      default: te_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ck_char(input logic [4:0] i);
    case (i)
      5'd0: ck_char = "c";  5'd1: ck_char = "h";  5'd2: ck_char = "u";
      5'd3: ck_char = "n";  5'd4: ck_char = "k";  5'd5: ck_char = "e";
      5'd6: ck_char = "d";
      default: ck_char = 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] phase_class(input logic [3:0] ph);
    case (ph)
      PH_START:      phase_class = CLS_START;
      PH_HEADERS:    phase_class = CLS_HEADER;
      PH_BODY:       phase_class = CLS_BODY;
      PH_CHUNK_DATA: phase_class = CLS_BODY;
      PH_CHUNK_TERM: phase_class = CLS_TERM;
      PH_CHUNK_SIZE: phase_class = CLS_SIZE;
      PH_TRAILER:    phase_class = CLS_TRAILER;
      default:       phase_class = CLS_NONE;
    endcase
  endfunction

endpackage

// ----- rtl/hmf_parser.sv -----
module hmf_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               restart,
  output hmf_pkg::hmf_result_t result
);
  import hmf_pkg::*;

  logic [3:0]             phase_r, phase_nxt;
  logic                   cr_r, cr_nxt;
  logic [4:0]             pos_r, pos_nxt;
  logic [2:0]             flags_r, flags_nxt;
  logic [2:0]             vp_r, vp_nxt;
  logic                   chunked_r, chunked_nxt;
  logic                   lseen_r, lseen_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [1:0]             err_r, err_nxt;
  logic                   te_r, te_nxt;
  logic [1:0]             lstat_r, lstat_nxt;

  logic [2:0] cls;
  logic       lend, done;
  logic       do_char, empty;

  logic       hex_ok;
  logic [3:0] hex_d;
  logic       num_ovf;
  logic [LENGTH_BITS-1:0] num_val;
  logic [LENGTH_BITS+4:0] nsum;
  logic [LENGTH_BITS-1:0] abase;
  logic                   hexmode;
  logic [LENGTH_BITS+3:0] nprod;

  always_comb begin
    logic [3:0] ph;
    logic       cr;
    logic [4:0] pos;
    logic [2:0] fl;
    logic [2:0] vp;
    logic       ck, ls, te;
    logic [LENGTH_BITS-1:0] acc, rem;
    logic [1:0] er, lst;
    ph = phase_r; cr = cr_r; pos = pos_r; fl = flags_r; vp = vp_r;
    ck = chunked_r; ls = lseen_r; te = te_r; acc = acc_r; rem = rem_r;
    er = err_r; lst = lstat_r;
    if (restart) begin
      ph = PH_START; cr = 1'b0; pos = '0; fl = '0; vp = VP_LEAD;
      ck = 1'b0; ls = 1'b0; te = 1'b0; acc = '0; rem = '0;
      er = ERR_NONE; lst = ERR_NONE;
    end
    cls = phase_class(ph);
    lend = 1'b0; done = 1'b0;
    do_char = 1'b0;
    empty = (pos == 5'd0) && !fl[2];
    if (cls == CLS_START || cls == CLS_HEADER || cls == CLS_SIZE ||
        cls == CLS_TERM || cls == CLS_TRAILER) begin
      if (cr && data_byte == CH_LF) begin
        cr = 1'b0;
        lend = 1'b1;
        unique case (ph)
          PH_START: ph = PH_HEADERS;
          PH_HEADERS: begin
            if (empty) begin
              if (ck) begin
                acc = '0; ph = PH_CHUNK_SIZE;
              end else if (ls) begin
                if (lst != ERR_NONE) begin
                  er = lst; ph = PH_ERROR;
                end else if (acc == '0) begin
                  ph = PH_DONE; done = 1'b1;
                end else begin
                  rem = acc; ph = PH_BODY;
                end
              end else begin
                ph = PH_DONE; done = 1'b1;
              end
            end else if (fl[2]) begin
              if (!fl[0] && !ls) begin
                ls = 1'b1;
                if (vp == VP_DIGITS || vp == VP_STOPPED) lst = ERR_NONE;
                else if (vp == VP_OVER) lst = ERR_OVER;
                else lst = ERR_MISSING;
              end
              if (!fl[1] && !te) begin
                te = 1'b1;
                ck = (vp == VP_DIGITS) && (pos == 5'd7);
              end
            end
          end
          PH_CHUNK_TERM: begin
            if (empty) begin
              acc = '0; ph = PH_CHUNK_SIZE;
            end else begin
              er = ERR_TERM; ph = PH_ERROR;
            end
          end
          PH_CHUNK_SIZE: begin
            if (vp == VP_LEAD || vp == VP_NONE) begin
              er = ERR_MISSING; ph = PH_ERROR;
            end else if (vp == VP_OVER) begin
              er = ERR_OVER; ph = PH_ERROR;
            end else if (acc == '0) begin
              ph = PH_TRAILER;
            end else begin
              rem = acc; ph = PH_CHUNK_DATA;
            end
            acc = '0;
          end
          PH_TRAILER: begin
            if (empty) begin
              ph = PH_DONE; done = 1'b1;
            end
          end
          default: ;
        endcase
        pos = '0; fl = '0; vp = VP_LEAD;
      end else begin
        // A pending lone CR is taken as content, then this byte, unless it is a CR.
        // The two cases never both need the character path in one cycle except
        // CR followed by a plain byte; that is handled below.
        do_char = 1'b1;
      end
    end else if (cls == CLS_BODY) begin
      if (rem != '0) rem = rem - 1'b1;
      if (rem == '0) begin
        if (ph == PH_BODY) begin
          ph = PH_DONE; done = 1'b1;
        end else ph = PH_CHUNK_TERM;
      end
    end

    phase_nxt = ph; cr_nxt = cr; pos_nxt = pos; flags_nxt = fl; vp_nxt = vp;
    chunked_nxt = ck; lseen_nxt = ls; te_nxt = te; acc_nxt = acc; rem_nxt = rem;
    err_nxt = er; lstat_nxt = lst;
  end

  // Character path. A stored CR followed by another byte feeds CR first; since a
  // CR is never a digit, name letter, colon or space, its effect is simple and
  // folded in before the byte itself.
  logic [3:0] s_ph;
  logic [4:0] s_pos;
  logic [2:0] s_fl, s_vp;
  logic       s_ls;
  logic [LENGTH_BITS-1:0] s_acc;
  logic       s_cr;

  hmf_result_t res_nxt;

  always_comb begin
    logic [4:0] p;
    logic [2:0] f, v;
    logic       crp;
    p = pos_nxt; f = flags_nxt; v = vp_nxt; crp = cr_nxt;
    s_ph = phase_nxt; s_ls = lseen_nxt; s_acc = acc_nxt;
    if (do_char) begin
      if (crp) begin
        crp = 1'b0;
        if (s_ph == PH_HEADERS) begin
          if (!f[2]) begin
            if (p >= 5'd14 || cl_char(p) != CH_CR) f[0] = 1'b1;
            if (p >= 5'd17 || te_char(p) != CH_CR) f[1] = 1'b1;
            if (p < 5'd31) p = p + 5'd1;
          end else if (!f[0] && !s_ls) begin
            if (v == VP_LEAD) v = VP_NONE;
            else if (v == VP_DIGITS) v = VP_STOPPED;
          end else if (!f[1]) begin
            v = VP_STOPPED;
          end
        end else begin
          if (s_ph == PH_CHUNK_SIZE) begin
            if (v == VP_LEAD) v = VP_NONE;
            else if (v == VP_DIGITS) v = VP_STOPPED;
          end
          if (p < 5'd31) p = p + 5'd1;
        end
      end
      if (data_byte == CH_CR) begin
        crp = 1'b1;
      end else if (s_ph == PH_HEADERS) begin
        if (!f[2]) begin
          if (data_byte == ":") begin
            if (p != 5'd14) f[0] = 1'b1;
            if (p != 5'd17) f[1] = 1'b1;
            f[2] = 1'b1; p = '0; v = VP_LEAD;
          end else begin
            if (p >= 5'd14 || cl_char(p) != data_byte) f[0] = 1'b1;
            if (p >= 5'd17 || te_char(p) != data_byte) f[1] = 1'b1;
            if (p < 5'd31) p = p + 5'd1;
          end
        end else if (v == VP_LEAD && data_byte == " ") begin
          v = v;
        end else if (!f[0] && !s_ls) begin
          if (data_byte >= "0" && data_byte <= "9" && v <= VP_DIGITS) begin
            v = VP_DIGITS;
            if (num_ovf) v = VP_OVER;
            else s_acc = num_val;
          end else if (v == VP_LEAD) v = VP_NONE;
          else if (v == VP_DIGITS) v = VP_STOPPED;
        end else if (!f[1]) begin
          if (v <= VP_DIGITS && p < 5'd7 && ck_char(p) == data_byte) begin
            v = VP_DIGITS; p = p + 5'd1;
          end else v = VP_STOPPED;
        end
      end else begin
        if (s_ph == PH_CHUNK_SIZE &&
            !(v == VP_LEAD && (data_byte == " " || data_byte == 8'h09))) begin
          if (hex_ok && v <= VP_DIGITS) begin
            v = VP_DIGITS;
            if (num_ovf) v = VP_OVER;
            else s_acc = num_val;
          end else if (v == VP_LEAD) v = VP_NONE;
          else if (v == VP_DIGITS) v = VP_STOPPED;
        end
        if (p < 5'd31) p = p + 5'd1;
      end
    end
    s_pos = p; s_fl = f; s_vp = v; s_cr = crp;
  end

  always_comb begin
    hex_ok = 1'b1; hex_d = '0;
    if (data_byte >= "0" && data_byte <= "9") hex_d = data_byte[3:0];
    else if ((data_byte >= "a" && data_byte <= "f") ||
             (data_byte >= "A" && data_byte <= "F")) hex_d = data_byte[3:0] + 4'd9;
    else hex_ok = 1'b0;
  end

  // The accumulator is only touched by digits, so acc_nxt equals acc_r here
  // unless restart cleared it. Base is 10 or 16: shifts and adds, then one
  // overflow compare.
  always_comb begin
    abase = restart ? '0 : acc_r;
    hexmode = (phase_nxt == PH_CHUNK_SIZE);
    if (hexmode) nprod = {abase, 4'd0};
    else nprod = {1'b0, abase, 3'd0} + {3'd0, abase, 1'b0};
    nsum = {1'b0, nprod} + {{(LENGTH_BITS+1){1'b0}}, (hexmode ? hex_d : data_byte[3:0])};
    num_ovf = (nsum[LENGTH_BITS+4:LENGTH_BITS] != '0);
    num_val = nsum[LENGTH_BITS-1:0];
  end

  always_comb begin
    res_nxt.data_byte = data_byte;
    res_nxt.byte_class = cls;
    res_nxt.line_end = lend;
    res_nxt.message_done = done;
    res_nxt.error_code = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START; cr_r <= 1'b0; pos_r <= '0; flags_r <= '0;
      vp_r <= VP_LEAD; chunked_r <= 1'b0; lseen_r <= 1'b0; te_r <= 1'b0;
      acc_r <= '0; rem_r <= '0; err_r <= ERR_NONE; lstat_r <= ERR_NONE;
    end else if (step) begin
      phase_r <= s_ph; cr_r <= s_cr; pos_r <= s_pos; flags_r <= s_fl;
      vp_r <= s_vp; chunked_r <= chunked_nxt; lseen_r <= s_ls; te_r <= te_nxt;
      acc_r <= s_acc; rem_r <= rem_nxt; err_r <= err_nxt; lstat_r <= lstat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) result <= res_nxt;
  end

endmodule

// ----- rtl/http_message_framer.sv -----
// Channel  Direction  Payload
// in_      slave      tdata {data_byte}, tuser {restart}
// out_     master     tdata {byte_out, byte_class, line_end, message_done, error_code}
// One byte per cycle sustained while out_tready holds; the result appears in the cycle after acceptance.
// The parse state update is a single registered pass per byte.
// Reset clears all parse state; the output register holds one result.
// A stalled output stops input acceptance only while the result is not taken.
module http_message_framer #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // byte_out, byte_class, line_end, message_done,
                                  // error_code, zero pad
);
  import hmf_pkg::*;

  hmf_result_t res;
  logic        step;
  logic        vld_r;

  assign in_tready = !vld_r || out_tready;
  assign step = in_tvalid && in_tready;

  hmf_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk(clk), .rst_n(rst_n), .step(step),
    .data_byte(in_tdata), .restart(in_tuser), .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (in_tready) vld_r <= in_tvalid;
  end

  assign out_tvalid = vld_r;
  assign out_tdata = {1'b0, res.error_code, res.message_done, res.line_end,
                      res.byte_class, res.data_byte};

endmodule

// ----- rtl/hmf_checker.sv -----
module hmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  import hmf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word produced no result");

  a_lend: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tdata[7:0] == CH_LF)
    else $error("line end on non-LF byte");

  a_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:8] != 3'd7)
    else $error("bad byte class");

endmodule

bind http_message_framer hmf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
